[hdl/chm_pkg.sv]
// Shared types and constants for the chained hash map.
package chm_pkg;

  localparam int unsigned CHM_BUCKETS = 16;
  localparam int unsigned CHM_ENTRIES = 256;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Write enables of the entry memory
  typedef struct packed {
    logic key_we;
    logic val_we;
    logic nxt_we;
  } chm_we_t;

endpackage

[hdl/chm_entry_mem.sv]
// Entry storage: key, value and chain link memories, one write and one read port.
module chm_entry_mem #(
  parameter int unsigned ENTRIES = chm_pkg::CHM_ENTRIES,
  parameter int unsigned IW      = $clog2(ENTRIES),
  parameter int unsigned PW      = IW + 1
) (
  input  logic            clk_i,
  input  logic [IW-1:0]   rd_addr_i,
  input  chm_pkg::chm_we_t we_i,
  input  logic [IW-1:0]   wr_addr_i,
  input  logic [63:0]     wr_key_i,
  input  logic [63:0]     wr_val_i,
  input  logic [PW-1:0]   wr_nxt_i,
  output logic [63:0]     rd_key_o,
  output logic [63:0]     rd_val_o,
  output logic [PW-1:0]   rd_nxt_o
);
  import chm_pkg::*;

  logic [63:0]   key_mem [ENTRIES];
  logic [63:0]   val_mem [ENTRIES];
  logic [PW-1:0] nxt_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i.key_we) key_mem[wr_addr_i] <= wr_key_i;
    if (we_i.val_we) val_mem[wr_addr_i] <= wr_val_i;
    if (we_i.nxt_we) nxt_mem[wr_addr_i] <= wr_nxt_i;
    rd_key_o <= key_mem[rd_addr_i];
    rd_val_o <= val_mem[rd_addr_i];
    rd_nxt_o <= nxt_mem[rd_addr_i];
  end

endmodule

[hdl/chm_free_stack.sv]
// Free entry stack; positions never rewritten since a clear read their initial entry.
module chm_free_stack #(
  parameter int unsigned ENTRIES = chm_pkg::CHM_ENTRIES,
  parameter int unsigned IW      = $clog2(ENTRIES),
  parameter int unsigned PW      = IW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          pop_i,
  input  logic          push_i,
  input  logic [IW-1:0] push_idx_i,
  output logic [IW-1:0] top_o,
  output logic          empty_o
);
  import chm_pkg::*;

  logic [IW-1:0] mem [ENTRIES];
  logic [PW-1:0] fc_q, fc_d;
  logic [PW-1:0] lw_q, lw_d;
  logic [IW-1:0] pos;
  logic [IW-1:0] top_q;

  assign pos     = IW'(fc_q - PW'(1));
  assign empty_o = (fc_q == '0);
  assign top_o   = top_q;

  always_comb begin
    fc_d = fc_q;
    lw_d = lw_q;
    if (clr_i) begin
      fc_d = PW'(ENTRIES);
      lw_d = PW'(ENTRIES);
    end else if (pop_i) begin
      fc_d = fc_q - PW'(1);
      if (fc_d < lw_q) lw_d = fc_d;
    end else if (push_i) begin
      fc_d = fc_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= PW'(ENTRIES);
      lw_q <= PW'(ENTRIES);
    end else begin
      fc_q <= fc_d;
      lw_q <= lw_d;
    end
  end

  // Registered read of the stack top
  always_ff @(posedge clk_i) begin
    if (push_i && !clr_i) mem[fc_q[IW-1:0]] <= push_idx_i;
    if ({1'b0, pos} < lw_q) top_q <= IW'(ENTRIES - 1) - pos;
    else top_q <= mem[pos];
  end

endmodule

[hdl/chained_hash_map_top.sv]
// Top level of the chained hash map: command sequencer, bucket heads and result register.
//
// A key-value map with 64-bit keys and values. The key modulo BUCKETS picks a
// bucket and the chain of that bucket is walked in the entry memory, one link
// per cycle (a synchronous read per hop). When BUCKETS is a power of two the
// bucket is the low key bits; otherwise the bucket residue is folded one key
// byte per cycle before the walk. A put that links a new entry at a non-empty
// chain tail does the link write in a separate S_LINK state. One request is in
// flight at a time; a finished result waits in the output register while the
// next request is accepted. Entries come from a free stack of ENTRIES slots; a
// put on a full pool reports full_res_o.
module chained_hash_map_top #(
  parameter int unsigned BUCKETS = chm_pkg::CHM_BUCKETS,
  parameter int unsigned ENTRIES = chm_pkg::CHM_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] value_out_o,
  output logic        full_res_o,
  output logic [8:0]  entry_count_o,
  output logic        is_empty_o
);
  import chm_pkg::*;

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned PW   = IW + 1;
  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit          POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [PW-1:0] NIL   = PW'(ENTRIES);
  localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_HEAD = 6'b000100,
    S_WALK = 6'b001000,
    S_EXEC = 6'b010000,
    S_LINK = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Request registers
  cmd_e          cmd_q;
  logic [63:0]   key_q, val_q;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [2:0]    bc_q;

  // Walk registers
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] prev_q, prev_d;
  logic          hit_q, hit_d;
  logic [63:0]   hval_q, hval_d;
  logic [PW-1:0] hnxt_q, hnxt_d;
  logic [IW-1:0] new_q;

  // Bucket heads with valid bits
  logic [PW-1:0] head_q [BUCKETS];
  logic [BUCKETS-1:0] hvld_q;
  logic [PW-1:0] head_rd;

  logic [PW-1:0] cnt_q, cnt_d;

  // Result register
  logic          out_valid_q;
  logic          found_q, full_q, empty_q;
  logic [63:0]   vout_q;
  logic [8:0]    ecnt_q;
  logic [PW+8:0] cnt_ext;

  // Memory hookup
  logic [IW-1:0] rd_addr;
  chm_we_t       we;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_key, wr_val;
  logic [PW-1:0] wr_nxt;
  logic [63:0]   rd_key, rd_val;
  logic [PW-1:0] rd_nxt;

  logic          st_clr, st_pop, st_push, st_empty;
  logic [IW-1:0] st_top;

  logic          in_acc, out_free, act;
  logic          head_set;
  logic [PW-1:0] head_val;
  logic          done_found, done_full;
  logic [63:0]   done_vout;

  // Residue fold of one key byte
  logic [BW-1:0] res_nx;
  logic [BW:0]   fold;
  logic [7:0]    kbyte;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign act         = (state_q == S_EXEC) && out_free;
  assign head_rd     = hvld_q[bkt_q] ? head_q[bkt_q] : NIL;

  always_comb begin
    kbyte  = key_q[{bc_q, 3'b000} +: 8];
    res_nx = bkt_q;
    fold   = '0;
    for (int i = 7; i >= 0; i--) begin
      fold = {res_nx, kbyte[i]};
      if (fold >= (BW+1)'(BUCKETS)) fold = fold - (BW+1)'(BUCKETS);
      res_nx = fold[BW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    bkt_d      = bkt_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    hit_d      = hit_q;
    hval_d     = hval_q;
    hnxt_d     = hnxt_q;
    cnt_d      = cnt_q;
    rd_addr    = cur_q[IW-1:0];
    we         = '0;
    wr_addr    = cur_q[IW-1:0];
    wr_key     = key_q;
    wr_val     = val_q;
    wr_nxt     = NIL;
    st_clr     = 1'b0;
    st_pop     = 1'b0;
    st_push    = 1'b0;
    head_set   = 1'b0;
    head_val   = NIL;
    done_found = 1'b0;
    done_full  = 1'b0;
    done_vout  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_e'(cmd_i) == CMD_CLEAR) state_d = S_EXEC;
          else if (POW2) state_d = S_HEAD;
          else state_d = S_MOD;
          bkt_d = POW2 ? (key_i[BW-1:0] & BMASK) : '0;
        end
      end
      S_MOD: begin
        bkt_d = res_nx;
        if (bc_q == 3'd0) state_d = S_HEAD;
      end
      S_HEAD: begin
        prev_d  = NIL;
        cur_d   = head_rd;
        rd_addr = head_rd[IW-1:0];
        if (head_rd >= NIL) begin
          hit_d   = 1'b0;
          state_d = S_EXEC;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        rd_addr = rd_nxt[IW-1:0];
        if (rd_key == key_q) begin
          hit_d   = 1'b1;
          hval_d  = rd_val;
          hnxt_d  = rd_nxt;
          state_d = S_EXEC;
        end else begin
          prev_d = cur_q;
          cur_d  = rd_nxt;
          if (rd_nxt >= NIL) begin
            hit_d   = 1'b0;
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (cmd_q)
            CMD_PUT: begin
              if (hit_q) begin
                we.val_we  = 1'b1;
                done_found = 1'b1;
              end else if (st_empty) begin
                done_full = 1'b1;
              end else begin
                // Take a free entry and fill it
                st_pop    = 1'b1;
                we        = '{key_we: 1'b1, val_we: 1'b1, nxt_we: 1'b1};
                wr_addr   = st_top;
                wr_nxt    = NIL;
                cnt_d     = cnt_q + PW'(1);
                if (prev_q >= NIL) begin
                  head_set = 1'b1;
                  head_val = {1'b0, st_top};
                end else begin
                  state_d = S_LINK;
                end
              end
            end
            CMD_GET: begin
              done_found = hit_q;
              done_vout  = hit_q ? hval_q : '0;
            end
            CMD_REMOVE: begin
              done_found = hit_q;
              done_vout  = hit_q ? hval_q : '0;
              if (hit_q) begin
                // Unlink the match and return it to the pool
                st_push = 1'b1;
                if (cnt_q != '0) cnt_d = cnt_q - PW'(1);
                if (prev_q >= NIL) begin
                  head_set = 1'b1;
                  head_val = hnxt_q;
                end else begin
                  we.nxt_we = 1'b1;
                  wr_addr   = prev_q[IW-1:0];
                  wr_nxt    = hnxt_q;
                end
              end
            end
            CMD_CLEAR: begin
              st_clr = 1'b1;
              cnt_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_LINK: begin
        // Hook the new entry onto the old chain tail
        we.nxt_we = 1'b1;
        wr_addr   = prev_q[IW-1:0];
        wr_nxt    = {1'b0, new_q};
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cnt_ext = {9'd0, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hvld_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (act && cmd_q == CMD_CLEAR) hvld_q <= '0;
      else if (head_set) hvld_q[bkt_q] <= 1'b1;
      if (act) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
      val_q <= value_i;
      bc_q  <= 3'd7;
    end else if (state_q == S_MOD) begin
      bc_q <= bc_q - 3'd1;
    end
    bkt_q  <= bkt_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    hit_q  <= hit_d;
    hval_q <= hval_d;
    hnxt_q <= hnxt_d;
    if (act) new_q <= st_top;
    if (head_set) head_q[bkt_q] <= head_val;
    if (act) begin
      found_q <= done_found;
      full_q  <= done_full;
      vout_q  <= done_vout;
      ecnt_q  <= cnt_ext[8:0];
      empty_q <= (cnt_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign value_out_o   = vout_q;
  assign full_res_o    = full_q;
  assign entry_count_o = ecnt_q;
  assign is_empty_o    = empty_q;

  chm_entry_mem #(
    .ENTRIES(ENTRIES),
    .IW     (IW),
    .PW     (PW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_addr_i(rd_addr),
    .we_i     (we),
    .wr_addr_i(wr_addr),
    .wr_key_i (wr_key),
    .wr_val_i (wr_val),
    .wr_nxt_i (wr_nxt),
    .rd_key_o (rd_key),
    .rd_val_o (rd_val),
    .rd_nxt_o (rd_nxt)
  );

  chm_free_stack #(
    .ENTRIES(ENTRIES),
    .IW     (IW),
    .PW     (PW)
  ) u_free (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (st_clr),
    .pop_i     (st_pop),
    .push_i    (st_push),
    .push_idx_i(cur_q[IW-1:0]),
    .top_o     (st_top),
    .empty_o   (st_empty)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the chained hash map top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chm_pkg::*;

  localparam int unsigned NB = CHM_BUCKETS;
  localparam int unsigned NE = CHM_ENTRIES;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic        found;
    logic [63:0] value_out;
    logic        full_res;
    logic [8:0]  entry_count;
    logic        is_empty;
  } map_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = '0;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        found_o;
  logic [63:0] value_out_o;
  logic        full_res_o;
  logic [8:0]  entry_count_o;
  logic        is_empty_o;

  chained_hash_map_top i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow map: per-bucket chains of keys, plus a value per stored key.
  logic [63:0] chain_keys[NB][$];
  logic [63:0] shadow_vals[logic [63:0]];
  int unsigned shadow_count;

  map_result_t expected_results[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          hold_off;
  logic [63:0] known_keys[$];

  // Compute the result of one request and advance the shadow map.
  function automatic map_result_t predict_map(cmd_e cmd, logic [63:0] key, logic [63:0] val);
    map_result_t r;
    int unsigned b;
    int idx[$];
    r = '{default: '0};
    b = 32'(key % 64'(NB));
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NB; i++) chain_keys[i].delete();
        shadow_vals.delete();
        shadow_count = 0;
      end
      CMD_PUT: begin
        if (shadow_vals.exists(key)) begin
          shadow_vals[key] = val;
          r.found = 1'b1;
        end else if (shadow_count >= NE) begin
          r.full_res = 1'b1;
        end else begin
          shadow_vals[key] = val;
          chain_keys[b].push_back(key);
          shadow_count++;
        end
      end
      default: begin
        if (shadow_vals.exists(key)) begin
          r.found = 1'b1;
          r.value_out = shadow_vals[key];
          if (cmd == CMD_REMOVE) begin
            idx = chain_keys[b].find_first_index(k) with (k == key);
            chain_keys[b].delete(idx[0]);
            shadow_vals.delete(key);
            shadow_count--;
          end
        end
      end
    endcase
    r.entry_count = shadow_count[8:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  // Offer one request, hold it until accepted, and queue its expectation.
  task automatic send_request(cmd_e cmd, logic [63:0] key, logic [63:0] val);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    key_i <= key;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_map(cmd, key, val));
    if (cmd == CMD_PUT) known_keys.push_back(key);
  endtask

  task automatic idle_sender(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Pick a key: mostly previously used ones, else a fully random key.
  function automatic logic [63:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(0, 99) < 60)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    map_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual found=%b value=%h", $realtime, found_o,
                 value_out_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (found_o !== e.found || value_out_o !== e.value_out || full_res_o !== e.full_res ||
            entry_count_o !== e.entry_count || is_empty_o !== e.is_empty) begin
          $display("%0t: mismatch expected f=%b v=%h full=%b cnt=%0d emp=%b", $realtime,
                   e.found, e.value_out, e.full_res, e.entry_count, e.is_empty);
          $display("%0t:          actual   f=%b v=%h full=%b cnt=%0d emp=%b", $realtime,
                   found_o, value_out_o, full_res_o, entry_count_o, is_empty_o);
          fail_count++;
        end
      end
    end
  end

  // Stall the output on a pattern of its own; hold off long when asked.
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hold_off) out_stall_i <= 1'b1;
    else if (cycle_count % 2000 < 500) out_stall_i <= 1'b0;
    else out_stall_i <= (r < 35);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Extreme keys and values, every command, zero value, misses and clear.
  task automatic test_directed();
    send_request(CMD_GET, 64'd0, 64'd0);
    send_request(CMD_REMOVE, 64'd5, 64'd0);
    send_request(CMD_PUT, 64'd0, 64'd0);
    send_request(CMD_GET, 64'd0, '1);
    send_request(CMD_PUT, '1, '1);
    send_request(CMD_PUT, 64'd16, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(CMD_PUT, 64'd32, 64'h5A5A_A5A5_F0F0_0F0F);
    send_request(CMD_PUT, 64'd16, 64'd7);
    send_request(CMD_GET, 64'd16, 64'd0);
    send_request(CMD_GET, 64'd48, 64'd0);
    send_request(CMD_REMOVE, 64'd16, 64'd0);
    send_request(CMD_GET, 64'd32, 64'd0);
    send_request(CMD_REMOVE, 64'd0, 64'd0);
    send_request(CMD_GET, '1, 64'd0);
    send_request(CMD_CLEAR, '1, '1);
    send_request(CMD_GET, '1, 64'd0);
    idle_sender(1);
  endtask

  // Fill the pool past capacity, then drain part of it and refill.
  task automatic test_pool_full();
    for (int i = 0; i < NE + 3; i++)
      send_request(CMD_PUT, {$urandom, $urandom}, {$urandom, $urandom});
    send_request(CMD_PUT, known_keys[known_keys.size() - 10], 64'd99);
    for (int i = 0; i < 8; i++) send_request(CMD_REMOVE, pick_key(), 64'd0);
    for (int i = 0; i < 10; i++) send_request(CMD_PUT, {$urandom, $urandom}, 64'd1);
    send_request(CMD_CLEAR, 64'd0, 64'd0);
    known_keys.delete();
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      for (int i = 0; i < 20; i++) send_request(CMD_PUT, pick_key(), {$urandom, $urandom});
      repeat (300) @(posedge clk_i);
    join_any
    hold_off = 1'b0;
    wait fork;
  endtask

  // Random mix in bursts with gaps; keys reuse earlier ones to build chains.
  task automatic test_random(int unsigned n);
    int unsigned burst;
    cmd_e c;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        case ($urandom_range(0, 99)) inside
          [0:44]:  c = CMD_PUT;
          [45:69]: c = CMD_GET;
          [70:97]: c = CMD_REMOVE;
          default: c = CMD_CLEAR;
        endcase
        send_request(c, pick_key(), ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom});
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    idle_sender(1);
  endtask

  initial begin
    for (int i = 0; i < NB; i++) chain_keys[i].delete();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_pool_full();
    test_random(285);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
